// ===== design/vole_pkg.sv =====
package vole_pkg;

    // Widths of the byte and of the float fields.
    localparam int BYTE_W      = 8;
    localparam int FLOAT_MAN_W = 4;
    localparam int FLOAT_EXP_W = 3;

    // Operation codes as they arrive on the input channel.
    typedef enum logic [2:0] {
        OP_WRITE_IMM = 3'd0,
        OP_READ      = 3'd1,
        OP_ADD_INT   = 3'd2,
        OP_ADD_FLOAT = 3'd3,
        OP_OR        = 3'd4,
        OP_AND       = 3'd5,
        OP_XOR       = 3'd6,
        OP_ROTATE    = 3'd7
    } t_opcode;

    // Operands handed to the ALU.
    typedef struct packed {
        t_opcode             op;
        logic [BYTE_W-1:0]   a;
        logic [BYTE_W-1:0]   b;
        logic [BYTE_W-1:0]   imm;
        logic [2:0]          amt;
    } t_alu_in;

    // Result and status coming back from the ALU.
    typedef struct packed {
        logic [BYTE_W-1:0]   value;
        logic                sat;
    } t_alu_out;

endpackage

// ===== design/vole_if.sv =====
// Input channel: one instruction per beat.
interface vole_in_if import vole_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [2:0]          opcode;
    logic [3:0]          dest_reg;
    logic [3:0]          src_a;
    logic [3:0]          src_b;
    logic [3:0]          rotate_amount;
    logic [BYTE_W-1:0]   immediate_value;

    modport source (
        output valid, opcode, dest_reg, src_a, src_b, rotate_amount, immediate_value,
        input  ready
    );
    modport sink (
        input  valid, opcode, dest_reg, src_a, src_b, rotate_amount, immediate_value,
        output ready
    );
endinterface

// Output channel: one result per beat.
interface vole_out_if import vole_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   result_value;
    logic [3:0]          result_reg;
    logic                was_write;
    logic                float_saturated;

    modport source (
        output valid, result_value, result_reg, was_write, float_saturated,
        input  ready
    );
    modport sink (
        input  valid, result_value, result_reg, was_write, float_saturated,
        output ready
    );
endinterface

// ===== design/vole_alu.sv =====
module vole_alu import vole_pkg::*; (
    input  t_alu_in  i_req,
    output t_alu_out o_rsp
);

    logic [10:0]         mag_a;
    logic [10:0]         mag_b;
    logic signed [12:0]  fix_a;
    logic signed [12:0]  fix_b;
    logic signed [12:0]  fix_sum;
    logic                sum_neg;
    logic [11:0]         sum_mag;
    logic [FLOAT_EXP_W-1:0] norm_exp;
    logic [FLOAT_MAN_W-1:0] norm_man;
    logic [BYTE_W-1:0]   float_val;
    logic                float_sat;
    logic [2*BYTE_W-1:0] rot_wide;

    // Float operands to signed fixed point with eight fraction bits.
    always_comb begin
        mag_a = {7'd0, i_req.a[FLOAT_MAN_W-1:0]} << i_req.a[6:4];
        mag_b = {7'd0, i_req.b[FLOAT_MAN_W-1:0]} << i_req.b[6:4];
        fix_a = $signed({2'b00, mag_a});
        fix_b = $signed({2'b00, mag_b});
        if (i_req.a[7]) begin
            fix_a = -fix_a;
        end
        if (i_req.b[7]) begin
            fix_b = -fix_b;
        end
        fix_sum = fix_a + fix_b;
        sum_neg = fix_sum[12];
        sum_mag = sum_neg ? 12'(-fix_sum) : fix_sum[11:0];
    end

    // Normalize to the highest set bit, truncate, saturate at 8.0.
    always_comb begin
        norm_exp = '0;
        for (int k = 1; k < 8; k++) begin
            if (sum_mag[k+3]) begin
                norm_exp = FLOAT_EXP_W'(k);
            end
        end
        norm_man  = FLOAT_MAN_W'(sum_mag >> norm_exp);
        float_sat = sum_mag[11];
        if (float_sat) begin
            float_val = {sum_neg, 7'h7F};
        end else begin
            float_val = {sum_neg, norm_exp, norm_man};
        end
    end

    assign rot_wide = {i_req.a, i_req.a} >> i_req.amt;

    // Operation select.
    always_comb begin
        o_rsp.sat = 1'b0;
        case (i_req.op)
            OP_WRITE_IMM: o_rsp.value = i_req.imm;
            OP_READ:      o_rsp.value = i_req.a;
            OP_ADD_INT:   o_rsp.value = i_req.a + i_req.b;
            OP_ADD_FLOAT: begin
                o_rsp.value = float_val;
                o_rsp.sat   = float_sat;
            end
            OP_OR:        o_rsp.value = i_req.a | i_req.b;
            OP_AND:       o_rsp.value = i_req.a & i_req.b;
            OP_XOR:       o_rsp.value = i_req.a ^ i_req.b;
            OP_ROTATE:    o_rsp.value = rot_wide[BYTE_W-1:0];
            default:      o_rsp.value = '0;
        endcase
    end

endmodule

// ===== design/vole_alu_register_file.sv =====
// An accepted input beat is registered in the operand stage and then in the result register.
// Throughput: one instruction per cycle unless o_out stalls; a result may follow its predecessor
// directly, since the value written by one instruction is forwarded to the next.
// The register file reads at two ports into a registered operand stage.
// Reset (synchronous, active low) empties the pipeline and marks every register as zero.
module vole_alu_register_file import vole_pkg::*; #(
    parameter int REGISTER_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vole_in_if.sink     i_in,
    vole_out_if.source  o_out
);

    localparam int         IDX_W = $clog2(REGISTER_COUNT);
    localparam logic [8:0] RC9   = 9'(REGISTER_COUNT);

    // Reduce a 4-bit register field modulo the register count.
    function automatic logic [3:0] reduce_index(logic [3:0] f);
        logic [8:0] v;
        v = {5'd0, f};
        for (int k = 0; k < 8; k++) begin
            if (v >= RC9) begin
                v = v - RC9;
            end
        end
        return v[3:0];
    endfunction

    function automatic logic [IDX_W-1:0] to_addr(logic [3:0] r);
        logic [7:0] w;
        w = {4'd0, r};
        return w[IDX_W-1:0];
    endfunction

    logic [BYTE_W-1:0]         r_mem [REGISTER_COUNT];
    logic [REGISTER_COUNT-1:0] r_vld;

    logic              in_fire;
    logic              s1_adv;
    logic              s1_wr;
    t_opcode           in_op;
    logic [3:0]        in_rd;
    logic [3:0]        in_ra;
    logic [3:0]        in_rb;
    logic [3:0]        in_addr_a;

    logic              r_s1_valid;
    t_opcode           r_s1_op;
    logic [3:0]        r_s1_rd;
    logic [3:0]        r_s1_ra;
    logic [2:0]        r_s1_amt;
    logic [BYTE_W-1:0] r_s1_imm;
    logic [BYTE_W-1:0] r_rd_a;
    logic [BYTE_W-1:0] r_rd_b;
    logic              r_ok_a;
    logic              r_ok_b;
    logic              r_fwd_a;
    logic              r_fwd_b;
    logic [BYTE_W-1:0] r_fwd_val;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_value;
    logic [3:0]        r_out_reg;
    logic              r_out_wr;
    logic              r_out_sat;

    t_alu_in           alu_req;
    t_alu_out          alu_rsp;

    // Handshake and input decode.
    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign s1_wr      = (r_s1_op != OP_READ);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_fire    = i_in.valid && i_in.ready;
    assign in_op      = t_opcode'(i_in.opcode);
    assign in_rd      = reduce_index(i_in.dest_reg);
    assign in_ra      = reduce_index(i_in.src_a);
    assign in_rb      = reduce_index(i_in.src_b);
    assign in_addr_a  = (in_op == OP_ROTATE) ? in_rd : in_ra;

    // Operand stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_a    <= 1'b0;
            r_fwd_b    <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
                r_fwd_a    <= s1_adv && s1_wr && (r_s1_rd == in_addr_a);
                r_fwd_b    <= s1_adv && s1_wr && (r_s1_rd == in_rb);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Operand stage payload and register file reads.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_op  <= in_op;
            r_s1_rd  <= in_rd;
            r_s1_ra  <= in_ra;
            r_s1_amt <= i_in.rotate_amount[2:0];
            r_s1_imm <= i_in.immediate_value;
            r_rd_a   <= r_mem[to_addr(in_addr_a)];
            r_rd_b   <= r_mem[to_addr(in_rb)];
            r_ok_a   <= r_vld[to_addr(in_addr_a)];
            r_ok_b   <= r_vld[to_addr(in_rb)];
        end
        if (s1_adv && s1_wr) begin
            r_mem[to_addr(r_s1_rd)] <= alu_rsp.value;
            r_fwd_val               <= alu_rsp.value;
        end
    end

    // Written flags: a register never written reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (s1_adv && s1_wr) begin
            r_vld[to_addr(r_s1_rd)] <= 1'b1;
        end
    end

    // Operands with forwarding from the instruction just retired.
    always_comb begin
        alu_req.op  = r_s1_op;
        alu_req.imm = r_s1_imm;
        alu_req.amt = r_s1_amt;
        alu_req.a   = r_fwd_a ? r_fwd_val : (r_ok_a ? r_rd_a : '0);
        alu_req.b   = r_fwd_b ? r_fwd_val : (r_ok_b ? r_rd_b : '0);
    end

    vole_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_value <= alu_rsp.value;
            r_out_reg   <= s1_wr ? r_s1_rd : r_s1_ra;
            r_out_wr    <= s1_wr;
            r_out_sat   <= alu_rsp.sat;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.result_value    = r_out_value;
    assign o_out.result_reg      = r_out_reg;
    assign o_out.was_write       = r_out_wr;
    assign o_out.float_saturated = r_out_sat;

    // A retiring write marks its register as written.
    a_write_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && s1_wr |=> r_vld[$past(to_addr(r_s1_rd))])
        else $error("retired write did not mark its register");

    // Forwarding is only armed when a write retired on the same edge.
    a_fwd_needs_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && !(s1_adv && s1_wr) |=> !r_fwd_a && !r_fwd_b)
        else $error("forwarding armed without a retiring write");

    // A saturated float result carries the largest magnitude.
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_sat |-> r_out_value[6:0] == 7'h7F)
        else $error("saturated result is not the largest magnitude");

    // Only a write can report saturation.
    a_sat_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_wr |-> !r_out_sat)
        else $error("read reported float saturation");

    // An accepted beat occupies the operand stage on the next cycle.
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_s1_valid)
        else $error("accepted beat lost before the operand stage");

endmodule
